[rtl/pam_pkg.sv]
// Shared types and constants for the power alarm hysteresis monitor.
`timescale 1ns / 1ps

package pam_pkg;

  // Number of monitored nodes with stored samples
  localparam int NODE_COUNT = 16;

  // Field widths
  localparam int NODE_W = 4;
  localparam int MEAS_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Hysteresis margins: 0.1 V, 0.02 A, 2.0 degC
  localparam int VOLT_HYST_MV = 100;
  localparam int CURR_HYST_MA = 20;
  localparam int HEAT_HYST_DD = 20;

  // Result record slots, in output order
  localparam int SLOT_VOLT = 0;
  localparam int SLOT_CURR = 1;
  localparam int SLOT_HEAT = 2;
  localparam int SLOT_CHANGE = 3;
  localparam int SLOT_COUNT = 4;

  typedef enum logic [1:0] {
    SEV_NONE = 2'd0,
    SEV_WARN = 2'd1,
    SEV_CRIT = 2'd2
  } sev_e;

  typedef enum logic [1:0] {
    ALARM_OVER_VOLT  = 2'd0,
    ALARM_UNDER_VOLT = 2'd1,
    ALARM_OVER_CURR  = 2'd2,
    ALARM_OVER_HEAT  = 2'd3
  } alarm_e;

  typedef enum logic {
    REC_NODE_ALARM = 1'b0,
    REC_SEV_CHANGE = 1'b1
  } rec_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OV_CRIT = 3'd0,
    CFG_UV_CRIT = 3'd1,
    CFG_OV_WARN = 3'd2,
    CFG_UV_WARN = 3'd3,
    CFG_OC_CRIT = 3'd4,
    CFG_OC_WARN = 3'd5,
    CFG_OH_CRIT = 3'd6,
    CFG_OH_WARN = 3'd7
  } cfg_idx_e;

endpackage

[rtl/power_alarm_hysteresis_monitor.sv]
// Top level: per-node threshold alarms with hysteresis and scan severity tracking.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   node_index, voltage, current, temp, eos
// out      source     out_valid_o / out_stall_i record_kind, node, type, severity, last
// cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// A beat lands in the input register, is evaluated against the node's stored
// sample and moves into a four-slot record buffer. The buffer drains one
// record per cycle while the output is not stalled; an item makes zero to four
// records. An item with no records never waits.
// Reset clears limits to their defaults, the stored samples and severities.
// A stalled output holds its record; the input stalls only while the held
// item's records cannot enter the buffer.

module power_alarm_hysteresis_monitor
  import pam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Sample channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [NODE_W-1:0]     node_index_i,
  input  logic [MEAS_W-1:0]     voltage_mv_i,
  input  logic [MEAS_W-1:0]     current_ma_i,
  input  logic signed [MEAS_W-1:0] temp_decidegc_i,
  input  logic                  end_of_scan_i,
  // Record channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  record_kind_o,
  output logic [NODE_W-1:0]     alarm_node_o,
  output logic [1:0]            alarm_type_o,
  output logic [1:0]            severity_o,
  output logic                  last_of_run_o
);

  // Limit registers
  logic [MEAS_W-1:0]        ovc_q, uvc_q, ovw_q, uvw_q, occ_q, ocw_q;
  logic signed [MEAS_W-1:0] ohc_q, ohw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovc_q <= '1;
      uvc_q <= '0;
      ovw_q <= '1;
      uvw_q <= '0;
      occ_q <= '1;
      ocw_q <= '1;
      ohc_q <= 16'sh7FFF;
      ohw_q <= 16'sh7FFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OV_CRIT: ovc_q <= cfg_data_i;
        CFG_UV_CRIT: uvc_q <= cfg_data_i;
        CFG_OV_WARN: ovw_q <= cfg_data_i;
        CFG_UV_WARN: uvw_q <= cfg_data_i;
        CFG_OC_CRIT: occ_q <= cfg_data_i;
        CFG_OC_WARN: ocw_q <= cfg_data_i;
        CFG_OH_CRIT: ohc_q <= $signed(cfg_data_i);
        CFG_OH_WARN: ohw_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Input register
  logic                     s1_valid_q;
  logic [NODE_W-1:0]        s1_node_q;
  logic [MEAS_W-1:0]        s1_volt_q, s1_curr_q;
  logic signed [MEAS_W-1:0] s1_temp_q;
  logic                     s1_eos_q;
  logic                     s1_go;
  logic                     in_take;

  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_node_q <= node_index_i;
      s1_volt_q <= voltage_mv_i;
      s1_curr_q <= current_ma_i;
      s1_temp_q <= temp_decidegc_i;
      s1_eos_q  <= end_of_scan_i;
    end
  end

  // Stored samples per node
  logic [MEAS_W-1:0]        prev_volt_q [NODE_COUNT];
  logic [MEAS_W-1:0]        prev_curr_q [NODE_COUNT];
  logic signed [MEAS_W-1:0] prev_temp_q [NODE_COUNT];
  logic                     in_range;

  assign in_range = int'(s1_node_q) < NODE_COUNT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        prev_volt_q[i] <= '0;
        prev_curr_q[i] <= '0;
        prev_temp_q[i] <= '0;
      end
    end else if (s1_go && in_range) begin
      prev_volt_q[s1_node_q] <= s1_volt_q;
      prev_curr_q[s1_node_q] <= s1_curr_q;
      prev_temp_q[s1_node_q] <= s1_temp_q;
    end
  end

  logic [MEAS_W-1:0]        pv, pc;
  logic signed [MEAS_W-1:0] pt;

  assign pv = prev_volt_q[s1_node_q];
  assign pc = prev_curr_q[s1_node_q];
  assign pt = prev_temp_q[s1_node_q];

  // Widened hysteresis thresholds, never wrapping
  logic signed [MEAS_W+1:0] ovc_lo, ovw_lo, occ_lo, ocw_lo;
  logic [MEAS_W:0]          uvc_hi, uvw_hi;
  logic signed [MEAS_W:0]   ohc_lo, ohw_lo;

  assign ovc_lo = $signed({2'b00, ovc_q}) - $signed(18'(VOLT_HYST_MV));
  assign ovw_lo = $signed({2'b00, ovw_q}) - $signed(18'(VOLT_HYST_MV));
  assign occ_lo = $signed({2'b00, occ_q}) - $signed(18'(CURR_HYST_MA));
  assign ocw_lo = $signed({2'b00, ocw_q}) - $signed(18'(CURR_HYST_MA));
  assign uvc_hi = {1'b0, uvc_q} + 17'(VOLT_HYST_MV);
  assign uvw_hi = {1'b0, uvw_q} + 17'(VOLT_HYST_MV);
  assign ohc_lo = $signed({ohc_q[MEAS_W-1], ohc_q}) - $signed(17'(HEAT_HYST_DD));
  assign ohw_lo = $signed({ohw_q[MEAS_W-1], ohw_q}) - $signed(17'(HEAT_HYST_DD));

  logic signed [MEAS_W+1:0] pv_w, pc_w;
  logic signed [MEAS_W:0]   pt_w;

  assign pv_w = $signed({2'b00, pv});
  assign pc_w = $signed({2'b00, pc});
  assign pt_w = $signed({pt[MEAS_W-1], pt});

  // Evaluate voltage, current and temperature limits
  sev_e   v_sev, c_sev, t_sev, node_sev;
  alarm_e v_type;
  logic   v_rec, c_rec, t_rec;

  always_comb begin
    v_sev  = SEV_NONE;
    v_type = ALARM_OVER_VOLT;
    v_rec  = 1'b0;
    if (s1_volt_q >= ovc_q) begin
      v_sev = SEV_CRIT;
      v_rec = pv_w < ovc_lo;
    end else if (s1_volt_q <= uvc_q) begin
      v_sev  = SEV_CRIT;
      v_type = ALARM_UNDER_VOLT;
      v_rec  = {1'b0, pv} > uvc_hi;
    end else if (s1_volt_q >= ovw_q) begin
      v_sev = SEV_WARN;
      v_rec = pv_w < ovw_lo;
    end else if (s1_volt_q <= uvw_q) begin
      v_sev  = SEV_WARN;
      v_type = ALARM_UNDER_VOLT;
      v_rec  = {1'b0, pv} > uvw_hi;
    end
  end

  always_comb begin
    c_sev = SEV_NONE;
    c_rec = 1'b0;
    if (s1_curr_q >= occ_q) begin
      c_sev = SEV_CRIT;
      c_rec = pc_w < occ_lo;
    end else if (s1_curr_q >= ocw_q) begin
      c_sev = SEV_WARN;
      c_rec = pc_w < ocw_lo;
    end
  end

  always_comb begin
    t_sev = SEV_NONE;
    t_rec = 1'b0;
    if (s1_temp_q >= ohc_q) begin
      t_sev = SEV_CRIT;
      t_rec = pt_w < ohc_lo;
    end else if (s1_temp_q >= ohw_q) begin
      t_sev = SEV_WARN;
      t_rec = pt_w < ohw_lo;
    end
  end

  // Node severity is the worst of the three quantities
  always_comb begin
    node_sev = v_sev;
    if (c_sev > node_sev) node_sev = c_sev;
    if (t_sev > node_sev) node_sev = t_sev;
  end

  // Scan tracking
  sev_e scan_worst_q, reported_q, new_worst;
  logic change_rec;

  always_comb begin
    new_worst = scan_worst_q;
    if (in_range && (node_sev > scan_worst_q)) new_worst = node_sev;
  end

  assign change_rec = s1_eos_q && (new_worst != reported_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_worst_q <= SEV_NONE;
      reported_q   <= SEV_NONE;
    end else if (s1_go) begin
      scan_worst_q <= s1_eos_q ? SEV_NONE : new_worst;
      if (s1_eos_q) reported_q <= new_worst;
    end
  end

  // Record set made by the held item
  logic [SLOT_COUNT-1:0] new_mask;

  always_comb begin
    new_mask              = '0;
    new_mask[SLOT_VOLT]   = in_range && v_rec;
    new_mask[SLOT_CURR]   = in_range && c_rec;
    new_mask[SLOT_HEAT]   = in_range && t_rec;
    new_mask[SLOT_CHANGE] = change_rec;
  end

  // Record buffer
  logic [SLOT_COUNT-1:0] buf_valid_q, buf_valid_d;
  sev_e                  buf_sev_q [SLOT_COUNT];
  alarm_e                buf_vtype_q;
  logic [NODE_W-1:0]     buf_node_q;
  logic [SLOT_COUNT-1:0] pop_mask;
  logic                  out_take, buf_free;

  // Pick the lowest pending slot
  always_comb begin
    pop_mask = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (buf_valid_q[i]) begin
        pop_mask    = '0;
        pop_mask[i] = 1'b1;
      end
    end
  end

  assign out_take = out_valid_o && !out_stall_i;
  assign buf_free = (buf_valid_q == '0) || (out_take && last_of_run_o);
  assign s1_go    = s1_valid_q && ((new_mask == '0) || buf_free);

  always_comb begin
    buf_valid_d = out_take ? (buf_valid_q & ~pop_mask) : buf_valid_q;
    if (s1_go && (new_mask != '0)) buf_valid_d = new_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= '0;
    end else begin
      buf_valid_q <= buf_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && (new_mask != '0)) begin
      buf_node_q             <= s1_node_q;
      buf_vtype_q            <= v_type;
      buf_sev_q[SLOT_VOLT]   <= v_sev;
      buf_sev_q[SLOT_CURR]   <= c_sev;
      buf_sev_q[SLOT_HEAT]   <= t_sev;
      buf_sev_q[SLOT_CHANGE] <= new_worst;
    end
  end

  // Drive the record fields from the selected slot
  always_comb begin
    record_kind_o = REC_NODE_ALARM;
    alarm_node_o  = buf_node_q;
    alarm_type_o  = buf_vtype_q;
    severity_o    = buf_sev_q[SLOT_VOLT];
    if (pop_mask[SLOT_CURR]) begin
      alarm_type_o = ALARM_OVER_CURR;
      severity_o   = buf_sev_q[SLOT_CURR];
    end else if (pop_mask[SLOT_HEAT]) begin
      alarm_type_o = ALARM_OVER_HEAT;
      severity_o   = buf_sev_q[SLOT_HEAT];
    end else if (pop_mask[SLOT_CHANGE]) begin
      record_kind_o = REC_SEV_CHANGE;
      alarm_node_o  = '0;
      alarm_type_o  = ALARM_OVER_VOLT;
      severity_o    = buf_sev_q[SLOT_CHANGE];
    end
  end

  assign out_valid_o   = buf_valid_q != '0;
  assign last_of_run_o = $countones(buf_valid_q) == 1;

  // Checks
  a_volt_slot_sev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q[SLOT_VOLT] |-> buf_sev_q[SLOT_VOLT] != SEV_NONE)
    else $error("voltage record held with no severity");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && !buf_free)
    else $error("input stalled with nothing blocking");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !last_of_run_o) |=> out_valid_o)
    else $error("record run cut short");

  a_scan_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_eos_q) |=> scan_worst_q == SEV_NONE)
    else $error("scan severity not cleared at end of scan");

  a_change_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && change_rec) |=> buf_valid_q[SLOT_CHANGE] && reported_q != $past(reported_q))
    else $error("change record without a change of severity");

endmodule
